// ===== rtl/irpw_pkg.sv =====
// Shared types and constants for the infrared pulse-width frame decoder.
package irpw_pkg;

  // Decoder phases; codes above PH_RECOVER are unused and act as PH_WAIT_LOW.
  typedef enum logic [2:0] {
    PH_WAIT_LOW   = 3'd0,
    PH_LEAD_BURST = 3'd1,
    PH_LEAD_SPACE = 3'd2,
    PH_BIT_BURST  = 3'd3,
    PH_BIT_SPACE  = 3'd4,
    PH_RECOVER    = 3'd5
  } phase_e;

  // Frame status codes carried with every result.
  typedef enum logic {
    ST_DECODED        = 1'b0,
    ST_SHORT_PREAMBLE = 1'b1
  } frame_status_e;

  // Configuration register map.
  localparam int unsigned ApbAddrWidth  = 3;
  localparam int unsigned ApbDataWidth  = 32;
  localparam logic        RegPreambleMin = 1'b0;  // register index, paddr[2]
  localparam logic [7:0]  PreambleMinRst = 8'd154;

  localparam int unsigned MessageWidth = 16;

endpackage

// ===== rtl/irpw_in_if.sv =====
// Handshake channel that carries one receiver line sample per transfer.
interface irpw_in_if;
  logic valid;
  logic ready;
  logic line_sample;

  modport source (output valid, output line_sample, input ready);
  modport sink   (input valid, input line_sample, output ready);
endinterface

// ===== rtl/irpw_out_if.sv =====
// Handshake channel that carries one decoded frame result per transfer.
interface irpw_out_if;
  import irpw_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [MessageWidth-1:0] message;
  logic                    frame_status;

  modport source (output valid, output message, output frame_status, input ready);
  modport sink   (input valid, input message, input frame_status, output ready);
endinterface

// ===== rtl/ir_pulse_width_frame_decoder.sv =====
// Top level of the infrared pulse-width frame decoder with its APB register port.
// A sample accepted into the input register is decoded against the current phase when it
// advances, and its result (if any) is held in the output register until it is taken.
// Throughput: one sample per cycle, but a sample that produces a result waits while the
// output register is full and not read; other samples still enter while a result waits.
// Reset: rst_ni is asynchronous and active low; it returns the decoder to waiting for a
// low burst, clears counters and valid flags, and sets preamble_min to 154.
module ir_pulse_width_frame_decoder
  import irpw_pkg::*;
#(
  parameter int unsigned FRAME_BITS  = 32,
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  irpw_in_if.sink                 in_i,
  irpw_out_if.source              out_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ApbAddrWidth-1:0] paddr,
  input  logic [ApbDataWidth-1:0] pwdata,
  output logic [ApbDataWidth-1:0] prdata,
  output logic                    pready
);

  // Bit index needs to reach FRAME_BITS - 1 and address any bit of the shift register.
  localparam int unsigned IdxWidth = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
  localparam int unsigned BitCntWidth = $clog2(FRAME_BITS + 1);

  // ---------------------------------------------------------------------------
  // Configuration port. The register sits at byte address 0; the two low address
  // bits are ignored and paddr[2] selects the register index.
  // ---------------------------------------------------------------------------
  logic [7:0] preamble_min_q;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == RegPreambleMin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_min_q <= PreambleMinRst;
    end else if (cfg_write) begin
      preamble_min_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegPreambleMin) begin
      prdata = ApbDataWidth'(preamble_min_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. A sample is held here until it advances, and it is decoded against the
  // current phase when it advances.
  // ---------------------------------------------------------------------------
  logic in_valid_q;
  logic sample_q;
  logic advance;
  logic emit;

  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      sample_q <= in_i.line_sample;
    end
  end

  // ---------------------------------------------------------------------------
  // Decoder state.
  // ---------------------------------------------------------------------------
  phase_e                 phase_q, phase_d;
  logic [BitCntWidth-1:0] bit_index_q, bit_index_d;
  logic [COUNT_WIDTH-1:0] tick_count_q, tick_count_d;
  logic [COUNT_WIDTH-1:0] lead_width_q, lead_width_d;
  logic [FRAME_BITS-1:0]  bit_shift_q, bit_shift_d;

  // Shared decode terms.
  logic [COUNT_WIDTH-1:0] tick_inc;
  logic                   bit_is_one;
  logic [FRAME_BITS-1:0]  shift_new;
  logic [31:0]            shift_ext;
  logic                   last_bit;
  logic                   lead_short;

  // Space counts stick at all ones instead of wrapping on very long spaces.
  assign tick_inc   = (&tick_count_q) ? tick_count_q : tick_count_q + 1'b1;
  // A data bit is 1 when its space is longer than a quarter of the lead space.
  assign bit_is_one = tick_count_q > (lead_width_q >> 2);
  assign shift_new  = bit_shift_q |
                      (FRAME_BITS'(bit_is_one) << bit_index_q[IdxWidth-1:0]);
  assign shift_ext  = 32'(shift_new);
  assign last_bit   = bit_index_q == BitCntWidth'(FRAME_BITS - 1);
  // The lead space count is compared against the 8-bit threshold, zero extended.
  assign lead_short = 32'(tick_count_q) < 32'(preamble_min_q);

  // Next-state logic.
  always_comb begin
    phase_d      = phase_q;
    bit_index_d  = bit_index_q;
    tick_count_d = tick_count_q;
    lead_width_d = lead_width_q;
    bit_shift_d  = bit_shift_q;
    unique case (phase_q)
      PH_LEAD_BURST: begin
        if (sample_q) begin
          tick_count_d = COUNT_WIDTH'(1);
          phase_d      = PH_LEAD_SPACE;
        end
      end
      PH_LEAD_SPACE: begin
        if (sample_q) begin
          tick_count_d = tick_inc;
        end else begin
          lead_width_d = tick_count_q;
          if (lead_short) begin
            phase_d = PH_RECOVER;
          end else begin
            bit_index_d = '0;
            bit_shift_d = '0;
            phase_d     = PH_BIT_BURST;
          end
        end
      end
      PH_BIT_BURST: begin
        if (sample_q) begin
          tick_count_d = COUNT_WIDTH'(1);
          phase_d      = PH_BIT_SPACE;
        end
      end
      PH_BIT_SPACE: begin
        if (sample_q) begin
          tick_count_d = tick_inc;
        end else begin
          bit_shift_d = shift_new;
          bit_index_d = last_bit ? '0 : bit_index_q + 1'b1;
          phase_d     = last_bit ? PH_RECOVER : PH_BIT_BURST;
        end
      end
      PH_RECOVER: begin
        // Wait for the line to go idle again before looking for the next frame.
        if (sample_q) begin
          phase_d = PH_WAIT_LOW;
        end
      end
      default: begin
        // Waiting for a low burst; unused phase codes behave the same way.
        phase_d = sample_q ? PH_WAIT_LOW : PH_LEAD_BURST;
      end
    endcase
  end

  // Result logic: a result comes on the low sample that ends the lead space
  // (when too short) or the last data space.
  logic [MessageWidth-1:0] msg_d;
  logic                    status_d;

  always_comb begin
    emit     = 1'b0;
    msg_d    = '0;
    status_d = ST_DECODED;
    unique case (phase_q)
      PH_LEAD_SPACE: begin
        if (!sample_q && lead_short) begin
          emit     = 1'b1;
          status_d = ST_SHORT_PREAMBLE;
        end
      end
      PH_BIT_SPACE: begin
        if (!sample_q && last_bit) begin
          emit  = 1'b1;
          msg_d = {shift_ext[23:16], shift_ext[7:0]};
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // A sample only waits when it produces a result and the output is still full.
  assign advance = in_valid_q && (!emit || !out_o.valid || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_WAIT_LOW;
      bit_index_q  <= '0;
      tick_count_q <= '0;
      lead_width_q <= '0;
      bit_shift_q  <= '0;
    end else if (advance) begin
      phase_q      <= phase_d;
      bit_index_q  <= bit_index_d;
      tick_count_q <= tick_count_d;
      lead_width_q <= lead_width_d;
      bit_shift_q  <= bit_shift_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. It is refilled in the same cycle that its result is taken.
  // ---------------------------------------------------------------------------
  logic                    out_valid_q;
  logic [MessageWidth-1:0] message_q;
  logic                    status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      message_q <= msg_d;
      status_q  <= status_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.message      = message_q;
  assign out_o.frame_status = status_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == ST_SHORT_PREAMBLE) |-> message_q == '0)
    else $error("rejected preamble result carries a nonzero message");

  a_emit_to_recover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit |=> phase_q == PH_RECOVER && out_valid_q)
    else $error("result issued without entering recovery or filling the output");

  a_emit_on_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !sample_q && (phase_q == PH_LEAD_SPACE || phase_q == PH_BIT_SPACE))
    else $error("result raised outside the end of a space");

  a_bit_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(bit_index_q) < FRAME_BITS)
    else $error("bit index ran past the frame length");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> $stable(message_q) && $stable(status_q))
    else $error("pending result overwritten");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the infrared pulse-width frame decoder with a local predictor.
module tb_top;
  import irpw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The decoder is built with its default frame length and counter width.
  // The predictor below uses the same values.
  localparam int unsigned FrameBits  = 32;
  localparam int unsigned CountWidth = 8;
  localparam int          CountTop   = (1 << CountWidth) - 1;
  localparam logic [CountWidth-1:0] CountMax = '1;

  // The second register slot has no register behind it. Writes there must be ignored.
  localparam logic RegSpare = 1'b1;

  // Length of the forced receiver hold-off. It is long enough for results to pile up in
  // the output stage so that the decoder has to push back on the sample channel.
  localparam int HoldCycles   = 400;
  localparam int RandPhases   = 4;
  localparam int RandSamples  = 1300;
  localparam int RandFrames   = 12;   // results wanted per random phase

  // One decoder result as the predictor sees it.
  typedef struct packed {
    logic [MessageWidth-1:0] message;
    frame_status_e           status;
  } frame_result_t;

  // One row of the directed table describes a whole frame on the line: preamble_min to use,
  // the lead space length, how many bit spaces follow, and the space lengths for 0 and 1.
  // Rows marked typed carry their expected result. The other rows rely on the predictor.
  typedef struct packed {
    logic [7:0]    pmin;
    int            lead;
    int            nbits;
    logic [31:0]   pattern;
    int            zero_len;
    int            one_len;
    bit            typed;
    frame_result_t want;
  } frame_row_t;

  // The typed rows start from a clean line: each one follows a row that ends with the line
  // high and the decoder waiting for a burst. Truncated frames come last for that reason.
  frame_row_t frame_rows [14] = '{
    // Rows 1-3 run after reset with the reset threshold of 154.
    // A short lead space is rejected, and so is a lead space one tick below the threshold.
    '{8'd154,  10,  0, 32'h0000_0000,  0,   0, 1'b1, '{16'h0000, ST_SHORT_PREAMBLE}},
    '{8'd154, 153,  0, 32'h0000_0000,  0,   0, 1'b1, '{16'h0000, ST_SHORT_PREAMBLE}},
    // A lead space exactly at the threshold is accepted. Spaces of 38 and 39 ticks lie on
    // both sides of 154/4, so this row also checks the bit decision at its boundary.
    '{8'd154, 154, 32, 32'hC3A5_7E5A, 38,  39, 1'b1, '{16'hA55A, ST_DECODED}},
    // With a zero threshold a one-tick lead is accepted, and every space exceeds 1/4 = 0.
    '{8'd0,     1, 32, 32'hFFFF_FFFF,  1,   1, 1'b1, '{16'hFFFF, ST_DECODED}},
    '{8'd0,     8, 32, 32'h5A5A_A5A5,  2,   3, 1'b0, '{16'h0000, ST_DECODED}},
    '{8'd8,     7,  0, 32'h0000_0000,  0,   0, 1'b1, '{16'h0000, ST_SHORT_PREAMBLE}},
    // An all-zero message must come back with decoded status, not as a rejection.
    '{8'd8,     8, 32, 32'h0000_0000,  2,   3, 1'b1, '{16'h0000, ST_DECODED}},
    '{8'd8,     8, 32, 32'hFFFF_FFFF,  2,   3, 1'b1, '{16'hFFFF, ST_DECODED}},
    '{8'd8,    12, 32, 32'h1234_5678,  1,   4, 1'b0, '{16'h0000, ST_DECODED}},
    '{8'd255, 254,  0, 32'h0000_0000,  0,   0, 1'b1, '{16'h0000, ST_SHORT_PREAMBLE}},
    // A 300-tick lead must saturate at 255 and still pass the top threshold. Two 300-tick
    // bit spaces saturate too. If the counter wrapped, they would read as 44, below 63.
    '{8'd255, 300, 32, 32'h0001_0001, 63, 300, 1'b1, '{16'h0101, ST_DECODED}},
    '{8'd154, 200, 32, 32'h8001_7FFE, 20,  60, 1'b0, '{16'h0000, ST_DECODED}},
    // A frame cut off after five bits, then a full frame that the decoder reads out of step.
    '{8'd12,   40,  5, 32'h0000_0015,  3,  11, 1'b0, '{16'h0000, ST_DECODED}},
    '{8'd12,   12, 32, 32'hF0F0_0F0F,  3,   4, 1'b0, '{16'h0000, ST_DECODED}}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ApbAddrWidth-1:0] paddr;
  logic [ApbDataWidth-1:0] pwdata;
  logic [ApbDataWidth-1:0] prdata;
  logic                    pready;

  irpw_in_if  in_ch ();
  irpw_out_if out_ch ();

  ir_pulse_width_frame_decoder #(
    .FRAME_BITS (FrameBits),
    .COUNT_WIDTH(CountWidth)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted decoder state. It starts from the reset values. The block is reset only once,
  // so these values are never reloaded.
  phase_e                dec_phase        = PH_WAIT_LOW;
  logic [5:0]            dec_bit_idx      = '0;
  logic [CountWidth-1:0] dec_ticks        = '0;
  logic [CountWidth-1:0] dec_lead_w       = '0;
  logic [31:0]           dec_shreg        = '0;
  logic [7:0]            dec_preamble_min = PreambleMinRst;

  // Results still owed by the decoder, oldest first.
  frame_result_t pending_frames [$];

  // While a typed row is on the line, its table entry replaces the predicted result.
  bit            row_typed = 1'b0;
  frame_result_t row_want;

  // Quiet flags turn off idling on one side for a while.
  bit in_quiet  = 1'b0;
  bit out_quiet = 1'b0;

  int mismatch_count    = 0;
  int samples_sent      = 0;
  int results_predicted = 0;
  int decoded_seen      = 0;
  int rejected_seen     = 0;
  int settings_used     = 0;
  int holds_asked       = 0;
  int holds_done        = 0;

  function automatic void report_mismatch(input string what, input logic [31:0] want_v,
                                          input logic [31:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("ERROR %s: expected 0x%0h, got 0x%0h at %0t", what, want_v, got_v, $realtime);
    end
  endfunction

  // Most gaps are short or absent, and a few are long.
  function automatic int pick_gap(input bit quiet);
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // The tick counter stops at its top value instead of wrapping.
  function automatic logic [CountWidth-1:0] count_up(input logic [CountWidth-1:0] v);
    return (v == CountMax) ? v : v + 1'b1;
  endfunction

  // Advances the predicted decoder by one line sample.
  // Returns 1 when this sample ends a frame or a rejected lead space.
  function automatic bit decode_sample(input logic sample, output frame_result_t res);
    bit got;
    got = 1'b0;
    res = '{message: '0, status: ST_DECODED};
    case (dec_phase)
      PH_LEAD_BURST: begin
        if (sample) begin
          dec_ticks = 'd1;
          dec_phase = PH_LEAD_SPACE;
        end
      end
      PH_LEAD_SPACE: begin
        if (sample) begin
          dec_ticks = count_up(dec_ticks);
        end else begin
          // The low sample that ends the lead space settles whether the frame is kept.
          dec_lead_w = dec_ticks;
          if (dec_lead_w < dec_preamble_min) begin
            res       = '{message: '0, status: ST_SHORT_PREAMBLE};
            got       = 1'b1;
            dec_phase = PH_RECOVER;
          end else begin
            dec_bit_idx = '0;
            dec_shreg   = '0;
            dec_phase   = PH_BIT_BURST;
          end
        end
      end
      PH_BIT_BURST: begin
        if (sample) begin
          dec_ticks = 'd1;
          dec_phase = PH_BIT_SPACE;
        end
      end
      PH_BIT_SPACE: begin
        if (sample) begin
          dec_ticks = count_up(dec_ticks);
        end else begin
          // A bit is 1 when its space is longer than a quarter of the lead space.
          if (dec_ticks > (dec_lead_w >> 2)) dec_shreg[dec_bit_idx[4:0]] = 1'b1;
          dec_bit_idx = dec_bit_idx + 6'd1;
          if (dec_bit_idx >= FrameBits) begin
            res       = '{message: {dec_shreg[23:16], dec_shreg[7:0]}, status: ST_DECODED};
            got       = 1'b1;
            dec_phase = PH_RECOVER;
          end else begin
            dec_phase = PH_BIT_BURST;
          end
        end
      end
      PH_RECOVER: begin
        if (sample) dec_phase = PH_WAIT_LOW;
      end
      default: begin
        // Waiting for the low burst that opens a frame.
        if (!sample) dec_phase = PH_LEAD_BURST;
      end
    endcase
    return got;
  endfunction

  // Offers one sample after a random gap and holds it until the decoder takes it.
  // valid stays high from one transfer to the next unless a gap follows, so it never gets
  // two assignments in the same time step.
  task automatic send_sample(input logic sample);
    int            gap;
    frame_result_t res;
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.line_sample <= sample;
    do begin
      @(posedge clk_i);
    end while (in_ch.ready !== 1'b1);
    samples_sent++;
    if (decode_sample(sample, res)) begin
      pending_frames.push_back(row_typed ? row_want : res);
      results_predicted++;
    end
  endtask

  task automatic send_run(input logic level, input int count);
    repeat (count) send_sample(level);
  endtask

  // Puts one frame on the line: idle high, the opening burst, the lead space, then one burst
  // and one space per bit. A closing burst ends the last space, and the line returns high.
  // In varied mode the bursts are random and each space gets a random length on the correct
  // side of the quarter-lead threshold when it is above 0. A rare long space tests saturation.
  task automatic send_frame(input int lead, input int nbits, input logic [31:0] pattern,
                            input int zero_len, input int one_len, input int burst,
                            input bit vary);
    int thr;
    int len;
    thr = ((lead > CountTop) ? CountTop : lead) >> 2;
    send_run(1'b1, 2);
    send_run(1'b0, burst);
    send_run(1'b1, lead);
    for (int i = 0; i < nbits; i++) begin
      send_run(1'b0, vary ? $urandom_range(1, 3) : burst);
      if (!vary) begin
        len = pattern[i] ? one_len : zero_len;
      end else if (pattern[i]) begin
        len = ($urandom_range(0, 63) == 0) ? $urandom_range(250, 300)
                                           : $urandom_range(thr + 1, thr + 3);
      end else begin
        len = (thr == 0) ? 1 : $urandom_range(1, thr);
      end
      send_run(1'b1, len);
    end
    send_run(1'b0, burst);
    send_run(1'b1, 2);
  endtask

  // One register transfer over the APB port. The write takes effect at the access edge,
  // and read data is sampled at the same edge. The idle cycle at the end keeps psel from
  // getting two assignments in one step when transfers follow each other.
  task automatic apb_access(input logic wr, input logic idx,
                            input logic [ApbDataWidth-1:0] wdata,
                            output logic [ApbDataWidth-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stops the sample channel and waits for every owed result to arrive. The extra cycles
  // cover a sample still in the input stage that yields no result.
  task automatic settle_idle();
    in_ch.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes preamble_min while the decoder is idle and reads it back. When asked, a write to
  // the spare slot first checks that an out-of-range index leaves the register alone.
  task automatic set_preamble_min(input logic [7:0] value, input bit poke_spare);
    logic [ApbDataWidth-1:0] rd;
    settle_idle();
    apb_access(1'b1, RegPreambleMin, ApbDataWidth'(value), rd);
    dec_preamble_min = value;
    settings_used++;
    if (poke_spare) apb_access(1'b1, RegSpare, $urandom, rd);
    apb_access(1'b0, RegPreambleMin, '0, rd);
    if (rd[7:0] !== value) report_mismatch("preamble_min readback", value, rd[7:0]);
  endtask

  // One random stretch of line activity. Most are well-formed frames with random content.
  // The rest are lead spaces cut short, frames broken off early, and raw noise.
  task automatic run_random_unit();
    int roll;
    int lead;
    int lo;
    roll     = $urandom_range(0, 99);
    in_quiet = ($urandom_range(0, 3) == 0);
    lo       = (dec_preamble_min == 0) ? 1 : dec_preamble_min;
    if (roll < 55) begin
      lead = $urandom_range(lo, lo + 6);
      send_frame(lead, FrameBits, $urandom, 0, 0, $urandom_range(1, 3), 1'b1);
    end else if (roll < 78) begin
      lead = (dec_preamble_min > 1) ? $urandom_range(1, dec_preamble_min - 1) : 1;
      send_frame(lead, 0, '0, 0, 0, $urandom_range(1, 3), 1'b1);
    end else if (roll < 88) begin
      lead = $urandom_range(lo, lo + 6);
      send_frame(lead, $urandom_range(1, FrameBits - 1), $urandom, 0, 0,
                 $urandom_range(1, 3), 1'b1);
    end else begin
      repeat ($urandom_range(1, 40)) send_sample(logic'($urandom_range(0, 1)));
    end
  endtask

  // Result checker. A transfer on the result channel is compared with the oldest owed result.
  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("result with none owed", '0, out_ch.message);
      end else begin
        want = pending_frames.pop_front();
        if (out_ch.message !== want.message) begin
          report_mismatch("message", want.message, out_ch.message);
        end
        if (out_ch.frame_status !== want.status) begin
          report_mismatch("frame_status", want.status, out_ch.frame_status);
        end
        if (want.status == ST_DECODED) decoded_seen++;
        else rejected_seen++;
      end
    end
  end

  // Result receiver. It stalls at random, goes through quiet stretches with no stalls, and
  // serves each hold-off request by keeping ready low for the forced hold-off. The sample
  // channel keeps running during the hold-off.
  initial begin : result_receiver
    int gap;
    int loops;
    out_ch.ready <= 1'b0;
    loops = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (loops % 128 == 0) out_quiet = ($urandom_range(0, 3) == 0);
      loops++;
      if (holds_done < holds_asked) begin
        holds_done++;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        gap = pick_gap(out_quiet);
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Stimulus: reset, the directed table, then random phases at new thresholds.
  initial begin : line_stimulus
    logic [7:0] pmin_pick;
    int         base_samples;
    int         base_results;

    rst_ni            <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.line_sample <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames. A new threshold is written only when a row needs one, so the first
    // rows run at the value set by reset.
    foreach (frame_rows[r]) begin
      if (frame_rows[r].pmin != dec_preamble_min) set_preamble_min(frame_rows[r].pmin, 1'b0);
      in_quiet  = ($urandom_range(0, 3) == 0);
      row_typed = frame_rows[r].typed;
      row_want  = frame_rows[r].want;
      send_frame(frame_rows[r].lead, frame_rows[r].nbits, frame_rows[r].pattern,
                 frame_rows[r].zero_len, frame_rows[r].one_len, 2, 1'b0);
      row_typed = 1'b0;
    end

    // Random phases: the first at threshold zero, the middle ones at small thresholds, and
    // the last at a larger one. Every phase opens with a long receiver hold-off.
    base_samples = samples_sent;
    base_results = results_predicted;
    for (int p = 0; p < RandPhases; p++) begin
      if (p == 0) pmin_pick = 8'd0;
      else if (p == RandPhases - 1) pmin_pick = $urandom_range(20, 40);
      else pmin_pick = $urandom_range(1, 16);
      set_preamble_min(pmin_pick, p == 0);
      holds_asked++;
      while (samples_sent < base_samples + (p + 1) * RandSamples / RandPhases ||
             results_predicted < base_results + (p + 1) * RandFrames) begin
        run_random_unit();
      end
    end

    settle_idle();
    $display("Run covered %0d line samples at %0d written preamble_min settings.",
             samples_sent, settings_used);
    $display("Frames decoded: %0d, preambles rejected: %0d, receiver hold-offs: %0d.",
             decoded_seen, rejected_seen, holds_done);
    if (mismatch_count == 0 && pending_frames.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Timeout. This allows far more time than the slowest correct run, with every gap and
  // every stall at its longest.
  initial begin : run_limit
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
